// ----- hdl/dqd_pkg.sv -----
// ============================================================================
// dqd_pkg: shared types and constants for the debounced quadrature decoder
// Word formats, configuration set, controller states and the
// controller/datapath command and status structs.
// ============================================================================
package dqd_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VELOCITY_SCALE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_PERIOD_MS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEADY_LIMIT_MS  = 2'd3;

    // reset values
    localparam logic [9:0]  DEBOUNCE_COUNT_RST   = 10'd5;
    localparam logic [15:0] VELOCITY_SCALE_RST   = 16'd1;
    localparam logic [7:0]  SAMPLE_PERIOD_MS_RST = 8'd1;
    localparam logic [15:0] STEADY_LIMIT_MS_RST  = 16'd200;

    // restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // speed update fires when |position - anchor| exceeds this
    localparam logic [16:0] DELTA_LIMIT = 17'd2;

    typedef struct packed {
        logic        mode;
        logic        raw_a;
        logic        raw_b;
        logic signed [15:0] preset_position;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] position;
        logic signed [15:0] speed;
        logic               steady;
    } out_word_t;

    typedef struct packed {
        logic [9:0]  debounce_count;
        logic [15:0] velocity_scale;
        logic [7:0]  sample_period_ms;
        logic [15:0] steady_limit_ms;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;      // capture input word, debounce and decode
        logic mul;       // register |delta| * scale
        logic timer;     // advance timer or zero speed
        logic sum;       // add product to previous speed
        logic div_load;  // halve, set up divider
        logic div_step;  // one quotient bit
        logic finish;    // sign, saturate, renew anchor
        logic emit;      // load output register
    } dqd_cmd_t;

    typedef struct packed {
        logic is_load;
        logic big_delta;
        logic div_last;
        logic out_free;
    } dqd_stat_t;

endpackage

// ----- hdl/dqd_ctrl.sv -----
// ============================================================================
// dqd_ctrl: sequencing controller
// Walks one word through evaluate, multiply/add and serial divide when the speed updates, and emit.
// ============================================================================
module dqd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dqd_pkg::dqd_stat_t  stat,
    output dqd_pkg::dqd_cmd_t   cmd
);

    dqd_pkg::state_t state_reg;
    dqd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dqd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dqd_pkg::ST_IDLE: begin
                if (s_valid) state_next = dqd_pkg::ST_EVAL;
            end
            dqd_pkg::ST_EVAL: begin
                if (!stat.is_load && stat.big_delta) state_next = dqd_pkg::ST_SUM;
                else                                 state_next = dqd_pkg::ST_EMIT;
            end
            dqd_pkg::ST_SUM:      state_next = dqd_pkg::ST_DIV_LOAD;
            dqd_pkg::ST_DIV_LOAD: state_next = dqd_pkg::ST_DIV;
            dqd_pkg::ST_DIV: begin
                if (stat.div_last) state_next = dqd_pkg::ST_FINISH;
            end
            dqd_pkg::ST_FINISH:   state_next = dqd_pkg::ST_EMIT;
            dqd_pkg::ST_EMIT: begin
                if (stat.out_free) state_next = dqd_pkg::ST_IDLE;
            end
            default:              state_next = dqd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            dqd_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            dqd_pkg::ST_EVAL: begin
                cmd.mul   = !stat.is_load && stat.big_delta;
                cmd.timer = !stat.is_load && !stat.big_delta;
            end
            dqd_pkg::ST_SUM:      cmd.sum      = 1'b1;
            dqd_pkg::ST_DIV_LOAD: cmd.div_load = 1'b1;
            dqd_pkg::ST_DIV:      cmd.div_step = 1'b1;
            dqd_pkg::ST_FINISH:   cmd.finish   = 1'b1;
            dqd_pkg::ST_EMIT:     cmd.emit     = stat.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == dqd_pkg::ST_EVAL))
        else $error("accepted word did not start evaluation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dqd_pkg::ST_DIV && !stat.div_last) |=> (state_reg == dqd_pkg::ST_DIV))
        else $error("divider left before last step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dqd_pkg::ST_EMIT && stat.out_free) |=> (state_reg == dqd_pkg::ST_IDLE))
        else $error("emit did not return to idle");
`endif

endmodule

// ----- hdl/dqd_datapath.sv -----
// ============================================================================
// dqd_datapath: decoder state, speed arithmetic and output register
// Debouncer, quadrature decode, 16x16 multiplier, restoring divider.
// ============================================================================
module dqd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  dqd_pkg::cfg_t       cfg,
    input  dqd_pkg::in_word_t   s_word,
    input  dqd_pkg::dqd_cmd_t   cmd,
    output dqd_pkg::dqd_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output dqd_pkg::out_word_t  m_word
);

    // decoder state
    logic        raw_prev_a_reg, raw_prev_a_next;
    logic        raw_prev_b_reg, raw_prev_b_next;
    logic [9:0]  stable_cnt_reg, stable_cnt_next;
    logic        stable_a_reg, stable_a_next;
    logic        stable_b_reg, stable_b_next;
    logic        seen_a_reg, seen_a_next;
    logic        seen_b_reg, seen_b_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] anchor_reg, anchor_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [31:0] speed_reg, speed_next;
    logic        load_reg, load_next;

    // arithmetic pipeline
    logic [31:0] prod_reg, prod_next;
    logic        prod_neg_reg, prod_neg_next;
    logic [33:0] sum_reg, sum_next;
    logic [16:0] div_reg, div_next;
    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic        quo_neg_reg, quo_neg_next;
    logic [dqd_pkg::DIV_CNT_W-1:0] step_cnt_reg, step_cnt_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    dqd_pkg::out_word_t m_word_reg, m_word_next;

    // combinational helpers
    logic        same_pair;
    logic [9:0]  cnt_inc;
    logic        sa, sb;
    logic signed [2:0] step_a, step_b, step_sum;
    logic [15:0] pos_step;
    logic [16:0] delta, delta_mag;
    logic [33:0] prod_s, sum_mag;
    logic [17:0] shifted, diff;
    logic        ge;
    logic [31:0] speed_sat;
    logic [15:0] speed16;

    // debouncer: next stable pair
    always_comb begin
        raw_prev_a_next = raw_prev_a_reg;
        raw_prev_b_next = raw_prev_b_reg;
        stable_cnt_next = stable_cnt_reg;
        stable_a_next   = stable_a_reg;
        stable_b_next   = stable_b_reg;
        same_pair = (s_word.raw_a == raw_prev_a_reg) && (s_word.raw_b == raw_prev_b_reg);
        cnt_inc   = stable_cnt_reg + 10'd1;
        if (same_pair) begin
            if (stable_cnt_reg < cfg.debounce_count) begin
                stable_cnt_next = cnt_inc;
                if (cnt_inc == cfg.debounce_count) begin
                    stable_a_next = raw_prev_a_reg;
                    stable_b_next = raw_prev_b_reg;
                end
            end
        end else begin
            stable_cnt_next = '0;
            raw_prev_a_next = s_word.raw_a;
            raw_prev_b_next = s_word.raw_b;
        end
    end

    // quadrature decode on the new stable pair; A then B
    always_comb begin
        sa = stable_a_next;
        sb = stable_b_next;
        if (sa != seen_a_reg) step_a = (sa != sb) ? 3'sd1 : -3'sd1;
        else                  step_a = 3'sd0;
        if (sb != seen_b_reg) step_b = (sa == sb) ? 3'sd1 : -3'sd1;
        else                  step_b = 3'sd0;
        step_sum = step_a + step_b;
        pos_step = pos_reg + {{13{step_sum[2]}}, step_sum};
    end

    // unwrapped difference, -65535..65535
    always_comb begin
        delta     = {pos_reg[15], pos_reg} - {anchor_reg[15], anchor_reg};
        delta_mag = delta[16] ? (17'd0 - delta) : delta;
    end

    // divider step and saturation helpers
    always_comb begin
        prod_s  = prod_neg_reg ? (34'd0 - {2'b00, prod_reg}) : {2'b00, prod_reg};
        sum_mag = sum_reg[33] ? (34'd0 - sum_reg) : sum_reg;
        shifted = {rem_reg, quo_reg[31]};
        diff    = shifted - {1'b0, div_reg};
        ge      = (shifted >= {1'b0, div_reg});
        if (!quo_neg_reg) begin
            speed_sat = quo_reg[31] ? 32'h7FFF_FFFF : quo_reg;
        end else begin
            speed_sat = (quo_reg[31] && (|quo_reg[30:0])) ? 32'h8000_0000
                                                            : (32'd0 - quo_reg);
        end
        if ((&speed_reg[31:15]) || !(|speed_reg[31:15])) speed16 = speed_reg[15:0];
        else speed16 = speed_reg[31] ? 16'h8000 : 16'h7FFF;
    end

    always_comb begin
        elapsed_next  = elapsed_reg;
        speed_next    = speed_reg;
        pos_next      = pos_reg;
        anchor_next   = anchor_reg;
        seen_a_next   = seen_a_reg;
        seen_b_next   = seen_b_reg;
        load_next     = load_reg;
        prod_next     = prod_reg;
        prod_neg_next = prod_neg_reg;
        sum_next      = sum_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        quo_neg_next  = quo_neg_reg;
        step_cnt_next = step_cnt_reg;
        m_word_next   = m_word_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cmd.take) begin
            load_next = s_word.mode;
            if (s_word.mode) begin
                pos_next    = s_word.preset_position;
                anchor_next = s_word.preset_position;
            end else begin
                seen_a_next = sa;
                seen_b_next = sb;
                pos_next    = pos_step;
            end
        end

        if (cmd.mul) begin
            prod_next     = delta_mag[15:0] * cfg.velocity_scale;
            prod_neg_next = delta[16];
        end

        if (cmd.timer) begin
            if (elapsed_reg > {1'b0, cfg.steady_limit_ms}) speed_next = '0;
            else elapsed_next = elapsed_reg + {9'd0, cfg.sample_period_ms};
        end

        if (cmd.sum) begin
            sum_next = prod_s + {{2{speed_reg[31]}}, speed_reg};
        end

        if (cmd.div_load) begin
            quo_next      = sum_mag[32:1];   // |sum| / 2, toward zero
            quo_neg_next  = sum_reg[33];
            rem_next      = '0;
            div_next      = (elapsed_reg == 17'd0) ? 17'd1 : elapsed_reg;
            step_cnt_next = '0;
        end

        if (cmd.div_step) begin
            rem_next      = ge ? diff[16:0] : shifted[16:0];
            quo_next      = {quo_reg[30:0], ge};
            step_cnt_next = step_cnt_reg + 1'b1;
        end

        if (cmd.finish) begin
            speed_next   = speed_sat;
            anchor_next  = pos_reg;
            elapsed_next = '0;
        end

        if (cmd.emit) begin
            m_valid_next         = 1'b1;
            m_word_next.position = pos_reg;
            m_word_next.speed    = speed16;
            m_word_next.steady   = (elapsed_reg > {1'b0, cfg.steady_limit_ms});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_prev_a_reg <= 1'b0;
            raw_prev_b_reg <= 1'b0;
            stable_cnt_reg <= '0;
            stable_a_reg   <= 1'b0;
            stable_b_reg   <= 1'b0;
            seen_a_reg     <= 1'b0;
            seen_b_reg     <= 1'b0;
            pos_reg        <= '0;
            anchor_reg     <= '0;
            elapsed_reg    <= '0;
            speed_reg      <= '0;
            load_reg       <= 1'b0;
            step_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.take && !s_word.mode) begin
                raw_prev_a_reg <= raw_prev_a_next;
                raw_prev_b_reg <= raw_prev_b_next;
                stable_cnt_reg <= stable_cnt_next;
                stable_a_reg   <= stable_a_next;
                stable_b_reg   <= stable_b_next;
            end
            seen_a_reg   <= seen_a_next;
            seen_b_reg   <= seen_b_next;
            pos_reg      <= pos_next;
            anchor_reg   <= anchor_next;
            elapsed_reg  <= elapsed_next;
            speed_reg    <= speed_next;
            load_reg     <= load_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
        sum_reg      <= sum_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        quo_neg_reg  <= quo_neg_next;
        m_word_reg   <= m_word_next;
    end

    assign stat.is_load   = load_reg;
    assign stat.big_delta = (delta_mag > dqd_pkg::DELTA_LIMIT);
    assign stat.div_last  = (step_cnt_reg == dqd_pkg::DIV_CNT_W'(dqd_pkg::DIV_STEPS - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (elapsed_reg == 17'd0) && (anchor_reg == pos_reg))
        else $error("speed update did not renew anchor and timer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |=> (div_reg != 17'd0))
        else $error("divider loaded with zero divisor");
`endif

endmodule

// ----- hdl/debounced_quadrature_decoder_top.sv -----
// ============================================================================
// debounced_quadrature_decoder_top: debounced quadrature decoder, speed estimate
// Sequence: a load word or a tick without a speed update goes ST_IDLE,
//   ST_EVAL, ST_EMIT; a tick that updates the speed also passes ST_SUM,
//   ST_DIV_LOAD, the 32-step restoring divider in ST_DIV (one quotient bit
//   per cycle) and ST_FINISH. ST_EMIT holds until the output register is free.
//   No new input word is taken before the block is back in ST_IDLE; a finished
//   word waits in the output register while the next input word is taken.
// Reset (aresetn low, synchronous): decoder state, position, timer and speed
//   clear to zero, configuration returns to its defaults, no word pending.
// ============================================================================
module debounced_quadrature_decoder_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write port, no wait, no read-back
    input  logic                                cfg_we,
    input  logic [dqd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [dqd_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dqd_pkg::in_word_t                   s_word,

    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output dqd_pkg::out_word_t                  m_word
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the block is idle;
    // the block itself does not enforce this. The datapath reads them directly.
    // ------------------------------------------------------------------
    dqd_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                dqd_pkg::CFG_DEBOUNCE_COUNT:   cfg_next.debounce_count   = cfg_wdata[9:0];
                dqd_pkg::CFG_VELOCITY_SCALE:   cfg_next.velocity_scale   = cfg_wdata;
                dqd_pkg::CFG_SAMPLE_PERIOD_MS: cfg_next.sample_period_ms = cfg_wdata[7:0];
                dqd_pkg::CFG_STEADY_LIMIT_MS:  cfg_next.steady_limit_ms  = cfg_wdata;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_count   <= dqd_pkg::DEBOUNCE_COUNT_RST;
            cfg_reg.velocity_scale   <= dqd_pkg::VELOCITY_SCALE_RST;
            cfg_reg.sample_period_ms <= dqd_pkg::SAMPLE_PERIOD_MS_RST;
            cfg_reg.steady_limit_ms  <= dqd_pkg::STEADY_LIMIT_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Controller and datapath talk only through cmd and stat.
    // ------------------------------------------------------------------
    dqd_pkg::dqd_cmd_t  cmd;
    dqd_pkg::dqd_stat_t stat;

    dqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dqd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_word  (s_word),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

// ----- tb/dqd_motion_checker.sv -----
// ============================================================================
// dqd_motion_checker: result checker for the debounced quadrature decoder
// Tracks configuration writes and accepted input words, keeps its own copy of
// the debouncer, position counter, timer and speed estimate, and compares each
// result word field by field against the oldest expected word.
// ============================================================================
module dqd_motion_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [dqd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [dqd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  dqd_pkg::in_word_t                 s_word,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  dqd_pkg::out_word_t                m_word,
    output int                                errors,
    output int                                pending,
    output int                                words_checked,
    output int                                speed_updates,
    output int                                steady_words
);

    localparam logic   MODE_LOAD = 1'b1;
    localparam longint SAT32_HI  = 64'sd2147483647;
    localparam longint SAT32_LO  = -64'sd2147483648;

    dqd_pkg::cfg_t      cfg;
    logic               prev_a, prev_b;
    logic               stab_a, stab_b;
    logic               acted_a, acted_b;
    logic [9:0]         hold_cnt;
    logic signed [15:0] pos, anchor;
    logic [16:0]        elapsed;
    int                 speed;
    dqd_pkg::out_word_t expected_words[$];

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        errors++;
    endtask

    // advance the decoder by one input word, return the result word it gives
    task automatic decode_word(input dqd_pkg::in_word_t w, output dqd_pkg::out_word_t r);
        int     delta;
        longint acc;
        longint divisor;
        if (w.mode == MODE_LOAD) begin
            pos    = w.preset_position;
            anchor = w.preset_position;
        end else begin
            if (w.raw_a == prev_a && w.raw_b == prev_b) begin
                // count stops once it reaches or passes the limit
                if (hold_cnt < cfg.debounce_count) begin
                    hold_cnt = hold_cnt + 10'd1;
                    if (hold_cnt == cfg.debounce_count) begin
                        stab_a = prev_a;
                        stab_b = prev_b;
                    end
                end
            end else begin
                hold_cnt = '0;
                prev_a   = w.raw_a;
                prev_b   = w.raw_b;
            end
            // A handled before B, both may move in one tick
            if (stab_a != acted_a) begin
                pos     = (stab_a != stab_b) ? pos + 16'sd1 : pos - 16'sd1;
                acted_a = stab_a;
            end
            if (stab_b != acted_b) begin
                pos     = (stab_a == stab_b) ? pos + 16'sd1 : pos - 16'sd1;
                acted_b = stab_b;
            end
            // plain difference, no wrap
            delta = int'(pos) - int'(anchor);
            if (delta > int'(dqd_pkg::DELTA_LIMIT) ||
                delta < -int'(dqd_pkg::DELTA_LIMIT)) begin
                acc     = longint'(delta) * longint'(cfg.velocity_scale);
                divisor = (elapsed == '0) ? 64'sd1 : longint'(elapsed);
                acc     = (longint'(speed) + acc) / 64'sd2;
                acc     = acc / divisor;
                if (acc > SAT32_HI) begin
                    acc = SAT32_HI;
                end else if (acc < SAT32_LO) begin
                    acc = SAT32_LO;
                end
                speed   = int'(acc);
                anchor  = pos;
                elapsed = '0;
                speed_updates++;
            end else if (elapsed > {1'b0, cfg.steady_limit_ms}) begin
                speed = 0;
            end else begin
                elapsed = elapsed + 17'(cfg.sample_period_ms);
            end
        end
        r.position = pos;
        r.speed    = (speed > 32767) ? 16'sh7fff :
                     (speed < -32768) ? 16'sh8000 : 16'(speed);
        r.steady   = (elapsed > {1'b0, cfg.steady_limit_ms});
    endtask

    always @(posedge aclk) begin
        dqd_pkg::out_word_t want;
        dqd_pkg::out_word_t fresh;
        if (!aresetn) begin
            cfg.debounce_count   = dqd_pkg::DEBOUNCE_COUNT_RST;
            cfg.velocity_scale   = dqd_pkg::VELOCITY_SCALE_RST;
            cfg.sample_period_ms = dqd_pkg::SAMPLE_PERIOD_MS_RST;
            cfg.steady_limit_ms  = dqd_pkg::STEADY_LIMIT_MS_RST;
            {prev_a, prev_b, stab_a, stab_b, acted_a, acted_b} = '0;
            hold_cnt = '0;
            pos      = '0;
            anchor   = '0;
            elapsed  = '0;
            speed    = 0;
            expected_words.delete();
            pending  = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    dqd_pkg::CFG_DEBOUNCE_COUNT:   cfg.debounce_count   = cfg_wdata[9:0];
                    dqd_pkg::CFG_VELOCITY_SCALE:   cfg.velocity_scale   = cfg_wdata;
                    dqd_pkg::CFG_SAMPLE_PERIOD_MS: cfg.sample_period_ms = cfg_wdata[7:0];
                    dqd_pkg::CFG_STEADY_LIMIT_MS:  cfg.steady_limit_ms  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    flag_mismatch($sformatf("result with none outstanding: pos %0d speed %0d",
                                            m_word.position, m_word.speed));
                end else begin
                    want = expected_words.pop_front();
                    if (m_word.position !== want.position)
                        flag_mismatch($sformatf("position got %0d want %0d",
                                                m_word.position, want.position));
                    if (m_word.speed !== want.speed)
                        flag_mismatch($sformatf("speed got %0d want %0d",
                                                m_word.speed, want.speed));
                    if (m_word.steady !== want.steady)
                        flag_mismatch($sformatf("steady got %0b want %0b",
                                                m_word.steady, want.steady));
                    words_checked++;
                end
            end
            if (s_valid && s_ready) begin
                decode_word(s_word, fresh);
                expected_words.push_back(fresh);
                if (fresh.steady) steady_words++;
            end
            pending = expected_words.size();
        end
    end

endmodule

// ----- tb/tb_debounced_quadrature_decoder_top.sv -----
// ============================================================================
// tb_debounced_quadrature_decoder_top: stimulus and verdict for the decoder
// Drives shaft motion as debounced Gray-code walks, position presets and raw
// noise under a series of register settings, with random gaps on both sides
// and one long result backlog. Checking lives in dqd_motion_checker.
// ============================================================================
module tb_debounced_quadrature_decoder_top;

    localparam logic MODE_TICK      = 1'b0;
    localparam logic MODE_LOAD      = 1'b1;
    localparam int   RANDOM_WORDS   = 1850;
    localparam int   CALM_WORDS     = 250;     // tail of the run with no idling
    localparam int   DRAIN_CYCLES   = 40;
    localparam int   BACKLOG_CYCLES = 400;     // long result hold-off
    localparam int   LIMIT_CYCLES   = 600000;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [dqd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [dqd_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    dqd_pkg::in_word_t              s_word;
    logic                           m_valid;
    logic                           m_ready;
    dqd_pkg::out_word_t             m_word;

    // checker status
    int err_count, outstanding, checked, updates, steady_seen;

    // stimulus state
    int         words_sent;
    int         idle_odds;      // 1-in-N chance of a gap per word, 0 = none
    int         deb_now;        // debounce count currently programmed
    int         phases;
    logic [1:0] gray_idx;       // position in the 00,01,11,10 Gray sequence
    logic       hold_results;   // asks the receiver for one long hold-off

    debounced_quadrature_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    dqd_motion_checker motion_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word),
        .errors        (err_count),
        .pending       (outstanding),
        .words_checked (checked),
        .speed_updates (updates),
        .steady_words  (steady_seen)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // hard stop in case the handshake hangs
    initial begin
        #(2 * LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding",
                 LIMIT_CYCLES, outstanding);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request so the
    // output register fills, the controller waits in ST_EMIT and s_ready drops
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // one word through the input channel; entered and left at a falling edge
    task automatic send_word(input dqd_pkg::in_word_t w);
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic tick(input logic a, input logic b);
        dqd_pkg::in_word_t w;
        w.mode            = MODE_TICK;
        w.raw_a           = a;
        w.raw_b           = b;
        w.preset_position = 16'($urandom_range(0, 65535));   // ignored on ticks
        send_word(w);
    endtask

    task automatic load_position(input logic [15:0] preset);
        dqd_pkg::in_word_t w;
        w.mode            = MODE_LOAD;
        w.raw_a           = 1'($urandom_range(0, 1));        // ignored on loads
        w.raw_b           = 1'($urandom_range(0, 1));
        w.preset_position = preset;
        send_word(w);
    endtask

    // hold one Gray-cycle pair on A/B for n ticks
    task automatic hold_pair(input logic [1:0] idx, input int n);
        logic [1:0] ab;
        ab = {idx[1], idx[1] ^ idx[0]};
        repeat (n) tick(ab[1], ab[0]);
    endtask

    // one quadrature count; going back down the Gray cycle counts up
    task automatic step_shaft(input logic up, input int extra);
        gray_idx = up ? gray_idx - 2'd1 : gray_idx + 2'd1;
        hold_pair(gray_idx, deb_now + 1 + extra);
    endtask

    // break any stale debounce count, then land on the tracked pair
    task automatic resync();
        hold_pair(gray_idx + 2'd2, 1);
        hold_pair(gray_idx, deb_now + 1);
    endtask

    // drop valid and let the block drain before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [dqd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [dqd_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // low end, high end, or a random value up to mid_hi
    function automatic int pick_value(input int lo, input int hi, input int mid_hi);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(lo, mid_hi);
    endfunction

    initial begin
        int total;
        int phase_end;
        int pick;
        int steps;
        logic up;

        s_valid      = 1'b0;
        s_word       = '0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        aresetn      = 1'b0;
        hold_results = 1'b0;
        idle_odds    = 0;
        words_sent   = 0;
        phases       = 0;
        gray_idx     = 2'd0;
        deb_now      = int'(dqd_pkg::DEBOUNCE_COUNT_RST);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed: wrap across +/-32768 with full scale ----
        // Fast debounce, max scale, steady never reached.
        write_reg(dqd_pkg::CFG_DEBOUNCE_COUNT, 16'd1);
        deb_now = 1;
        write_reg(dqd_pkg::CFG_VELOCITY_SCALE, 16'hFFFF);
        write_reg(dqd_pkg::CFG_SAMPLE_PERIOD_MS, 16'd1);
        write_reg(dqd_pkg::CFG_STEADY_LIMIT_MS, 16'hFFFF);
        // Count up past the top: huge negative delta, speed near 32-bit min.
        load_position(16'h7FFF);
        step_shaft(1'b1, 0);
        // Same again on top of that speed: 32-bit saturation.
        load_position(16'h7FFF);
        step_shaft(1'b1, 0);
        // Count down past the bottom: huge positive delta.
        load_position(16'h8000);
        step_shaft(1'b0, 0);
        // 10 -> 01: both channels change in the same tick.
        gray_idx = 2'd1;
        hold_pair(gray_idx, 2);

        // ---- directed: debounce at max, then lowered under the count ----
        settle();
        write_reg(dqd_pkg::CFG_DEBOUNCE_COUNT, 16'd1023);
        deb_now = 1023;
        hold_pair(2'd0, 5);               // count climbs to 4
        settle();
        write_reg(dqd_pkg::CFG_DEBOUNCE_COUNT, 16'd2);
        deb_now = 2;
        hold_pair(2'd0, 2);               // already past 2: stays unaccepted
        gray_idx = 2'd2;
        hold_pair(gray_idx, 3);           // fresh pair is accepted normally

        // ---- directed: debounce of zero, steady limit zero, max period ----
        settle();
        write_reg(dqd_pkg::CFG_DEBOUNCE_COUNT, 16'd0);
        deb_now = 0;
        write_reg(dqd_pkg::CFG_SAMPLE_PERIOD_MS, 16'd255);
        write_reg(dqd_pkg::CFG_STEADY_LIMIT_MS, 16'd0);
        hold_pair(2'd3, 2);               // never accepted; steady right away

        // ---- random phases ----
        total = words_sent + RANDOM_WORDS;
        while (words_sent < total) begin
            settle();
            phases++;
            deb_now = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(1, 4);
            write_reg(dqd_pkg::CFG_DEBOUNCE_COUNT, 16'(deb_now));
            write_reg(dqd_pkg::CFG_VELOCITY_SCALE, 16'(pick_value(1, 65535, 65535)));
            write_reg(dqd_pkg::CFG_SAMPLE_PERIOD_MS, 16'(pick_value(1, 255, 20)));
            write_reg(dqd_pkg::CFG_STEADY_LIMIT_MS, 16'(pick_value(0, 65535, 80)));

            if (total - words_sent <= CALM_WORDS) begin
                phase_end = total;
                idle_odds = 0;
            end else begin
                phase_end = words_sent + $urandom_range(80, 200);
                pick      = $urandom_range(0, 2);
                idle_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
            end
            // one phase runs against a stalled receiver
            if (phases == 2) hold_results = 1'b1;

            resync();
            while (words_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    // clean run in one direction, random extra hold per step
                    steps = $urandom_range(1, 12);
                    up    = 1'($urandom_range(0, 1));
                    repeat (steps) step_shaft(up, $urandom_range(0, 2));
                end else if (pick < 77) begin
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        load_position(16'($urandom_range(32764, 32767)));
                    else if (pick == 1)
                        load_position(16'($urandom_range(32768, 32771)));
                    else
                        load_position(16'($urandom_range(0, 65535)));
                end else if (pick < 89) begin
                    // contact bounce, then back onto a known pair
                    repeat ($urandom_range(1, 10))
                        tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    resync();
                end else begin
                    // shaft at rest: timer runs toward steady
                    hold_pair(gray_idx, $urandom_range(1, 25));
                end
            end
        end

        // ---- drain and verdict ----
        s_valid <= 1'b0;
        for (pick = 0; pick < 20000 && outstanding != 0; pick++) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Run covered %0d words checked over %0d register settings", checked, phases + 3);
        $display("  with %0d speed recomputes and %0d steady results", updates, steady_seen);
        if (outstanding != 0) $display("%0d results never arrived", outstanding);
        if (err_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
